### sv/source_text_tokenizer_macros.svh
// Assertion shorthands shared by the tokenizer modules.
// Each expects clk_i and rst_ni in scope.
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

`define STT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define STT_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define STT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/stt_pkg.sv
`timescale 1ns / 1ps
package stt_pkg;

  // default counter widths
  localparam int STT_OFFSET_BITS = 32;
  localparam int STT_LINE_BITS   = 16;
  localparam int STT_COLUMN_BITS = 16;
  localparam int STT_LENGTH_BITS = 16;

  // fixed widths of the result fields
  localparam int OFS_FW  = 32;
  localparam int LINE_FW = 16;
  localparam int COL_FW  = 16;
  localparam int LEN_FW  = 16;

  // tokens per transaction bundle and bundles in the queue
  localparam int TOK_SLOTS   = 3;
  localparam int SLOT_W      = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] KIND_IDENT   = 3'd0;
  localparam logic [2:0] KIND_KEYWORD = 3'd1;
  localparam logic [2:0] KIND_NUMBER  = 3'd2;
  localparam logic [2:0] KIND_SYMBOL  = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         token_kind;
    logic [2:0]         keyword_index;
    logic [OFS_FW-1:0]  start_offset;
    logic [LEN_FW-1:0]  token_length;
    logic               length_clipped;
    logic [LINE_FW-1:0] start_line;
    logic [COL_FW-1:0]  start_column;
    logic [7:0]         first_char;
    logic [7:0]         second_char;
    logic               last_of_run;
  } out_item_t;

  // all tokens caused by one input transaction, in emission order
  typedef struct packed {
    logic [SLOT_W-1:0]            cnt;
    out_item_t [TOK_SLOTS-1:0]    tok;
  } bundle_t;

endpackage

### sv/stt_front.sv
`timescale 1ns / 1ps
`include "source_text_tokenizer_macros.svh"
module stt_front import stt_pkg::*; #(
  parameter int OFS_W  = STT_OFFSET_BITS,
  parameter int LINE_W = STT_LINE_BITS,
  parameter int COL_W  = STT_COLUMN_BITS,
  parameter int LEN_W  = STT_LENGTH_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  in_item_t in_data_i,
  output logic     push_o,
  output bundle_t  bundle_o
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_SYMBOL
  } scan_mode_e;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_US    = 8'h5F;

  localparam int KW_COUNT = 5;
  localparam int KW_LEN [KW_COUNT] = '{3, 5, 2, 4, 5};
  // byte 0 is the first character; unused bytes are zero like the prefix
  localparam logic [4:0][7:0] KW_TEXT [KW_COUNT] = '{
    {8'h00, 8'h00, "r", "a", "v"},
    {"e", "l", "i", "h", "w"},
    {8'h00, 8'h00, 8'h00, "f", "i"},
    {8'h00, "e", "s", "l", "e"},
    {"t", "n", "i", "r", "p"}
  };

  localparam logic [LEN_W-1:0]  LEN_MAX  = {LEN_W{1'b1}};
  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
  localparam logic [COL_W-1:0]  COL_MAX  = {COL_W{1'b1}};

  scan_mode_e        mode_q, mode_d;
  logic [OFS_W-1:0]  pos_q, pos_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [OFS_W-1:0]  tofs_q, tofs_d;
  logic [LINE_W-1:0] tline_q, tline_d;
  logic [COL_W-1:0]  tcol_q, tcol_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              over_q, over_d;
  logic [4:0][7:0]   pfx_q, pfx_d;

  logic [LEN_W-1:0] ext_len;
  logic             ext_over;
  logic [4:0][7:0]  ext_pfx, beg_pfx;
  logic             is_alpha, is_digit, is_space, is_lead;
  logic             byte_done, accept;
  logic             a_vld, m_vld, d_vld;
  out_item_t        a_rec, m_rec, d_rec;
  logic [7:0]       c;

  function automatic logic [2:0] mode_kind(input scan_mode_e m);
    logic [2:0] k;
    unique case (m)
      MODE_IDENT:  k = KIND_IDENT;
      MODE_NUMBER: k = KIND_NUMBER;
      default:     k = KIND_SYMBOL;
    endcase
    return k;
  endfunction

  function automatic out_item_t make_rec(input logic [2:0] kind,
                                         input logic [OFS_W-1:0] ofs,
                                         input logic [LINE_W-1:0] ln,
                                         input logic [COL_W-1:0] cl,
                                         input logic [LEN_W-1:0] len,
                                         input logic over,
                                         input logic [4:0][7:0] pfx);
    out_item_t  r;
    logic [2:0] k;
    logic [2:0] kw;
    k  = kind;
    kw = '0;
    if (kind == KIND_IDENT && !over && len <= LEN_W'(5)) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if (k == KIND_IDENT && len == LEN_W'(KW_LEN[i]) && pfx == KW_TEXT[i]) begin
          k  = KIND_KEYWORD;
          kw = 3'(i);
        end
      end
    end
    r.token_kind     = k;
    r.keyword_index  = kw;
    r.start_offset   = OFS_FW'(ofs);
    r.token_length   = LEN_FW'(len);
    r.length_clipped = over;
    r.start_line     = LINE_FW'(ln);
    r.start_column   = COL_FW'(cl);
    r.first_char     = pfx[0];
    r.second_char    = (len > LEN_W'(1)) ? pfx[1] : 8'h00;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  assign c      = in_data_i.text_byte;
  assign accept = in_valid_i && in_ready_i;

  assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_US;
  assign is_digit = c >= "0" && c <= "9";
  assign is_space = c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  assign is_lead  = c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT;

  always_comb begin
    ext_pfx = pfx_q;
    for (int i = 1; i < 5; i++) begin
      if (len_q == LEN_W'(i)) ext_pfx[i] = c;
    end
    ext_len  = (len_q == LEN_MAX) ? len_q : len_q + LEN_W'(1);
    ext_over = over_q | (len_q == LEN_MAX);
    beg_pfx    = '0;
    beg_pfx[0] = c;
  end

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    line_d  = line_q;
    col_d   = col_q;
    tofs_d  = tofs_q;
    tline_d = tline_q;
    tcol_d  = tcol_q;
    len_d   = len_q;
    over_d  = over_q;
    pfx_d   = pfx_q;
    byte_done = 1'b0;
    a_vld = 1'b0;
    m_vld = 1'b0;
    d_vld = 1'b0;
    a_rec = '0;
    m_rec = '0;
    d_rec = '0;

    if (in_data_i.byte_present) begin
      // pending token first: either it swallows the byte or it is flushed
      unique case (mode_q)
        MODE_IDENT, MODE_NUMBER: begin
          if (is_digit || (mode_q == MODE_IDENT && is_alpha)) begin
            len_d     = ext_len;
            over_d    = ext_over;
            pfx_d     = ext_pfx;
            byte_done = 1'b1;
          end else begin
            a_vld = 1'b1;
            a_rec = make_rec(mode_kind(mode_q), tofs_q, tline_q, tcol_q, len_q, over_q,
                             pfx_q);
          end
        end
        MODE_SYMBOL: begin
          a_vld = 1'b1;
          if (c == CH_EQ) begin
            a_rec = make_rec(KIND_SYMBOL, tofs_q, tline_q, tcol_q, ext_len, ext_over,
                             ext_pfx);
            mode_d    = MODE_IDLE;
            byte_done = 1'b1;
          end else begin
            a_rec = make_rec(KIND_SYMBOL, tofs_q, tline_q, tcol_q, len_q, over_q, pfx_q);
          end
        end
        default: ;
      endcase

      if (!byte_done) begin
        mode_d = MODE_IDLE;
        if (!is_space) begin
          tofs_d  = pos_q;
          tline_d = line_q;
          tcol_d  = col_q;
          len_d   = LEN_W'(1);
          over_d  = 1'b0;
          pfx_d   = beg_pfx;
          priority if (is_alpha) begin
            mode_d = MODE_IDENT;
          end else if (is_digit) begin
            mode_d = MODE_NUMBER;
          end else if (is_lead) begin
            mode_d = MODE_SYMBOL;
          end else begin
            m_vld = 1'b1;
            m_rec = make_rec(KIND_SYMBOL, pos_q, line_q, col_q, LEN_W'(1), 1'b0, beg_pfx);
          end
        end
      end

      pos_d = pos_q + OFS_W'(1);
      if (c == CH_LF) begin
        if (line_q != LINE_MAX) line_d = line_q + LINE_W'(1);
        col_d = COL_W'(1);
      end else if (col_q != COL_MAX) begin
        col_d = col_q + COL_W'(1);
      end
    end

    if (in_data_i.end_of_text) begin
      // a byte that emits a one-byte symbol leaves nothing pending
      if (mode_d != MODE_IDLE) begin
        m_vld = 1'b1;
        m_rec = make_rec(mode_kind(mode_d), tofs_d, tline_d, tcol_d, len_d, over_d, pfx_d);
      end
      d_vld = 1'b1;
      d_rec = make_rec(KIND_END, pos_d, line_d, col_d, '0, 1'b0, '0);
      d_rec.token_kind = KIND_END;
    end
  end

  // pack valid records into the leading slots
  always_comb begin
    bundle_o.cnt    = SLOT_W'(a_vld) + SLOT_W'(m_vld) + SLOT_W'(d_vld);
    bundle_o.tok[0] = a_vld ? a_rec : (m_vld ? m_rec : d_rec);
    bundle_o.tok[1] = (a_vld && m_vld) ? m_rec : d_rec;
    bundle_o.tok[2] = d_rec;
  end

  assign push_o = accept && (a_vld || m_vld || d_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      line_q  <= LINE_W'(1);
      col_q   <= COL_W'(1);
      tofs_q  <= '0;
      tline_q <= LINE_W'(1);
      tcol_q  <= COL_W'(1);
      len_q   <= '0;
      over_q  <= 1'b0;
      pfx_q   <= '0;
    end else if (accept) begin
      if (in_data_i.end_of_text) begin
        mode_q  <= MODE_IDLE;
        pos_q   <= '0;
        line_q  <= LINE_W'(1);
        col_q   <= COL_W'(1);
        tofs_q  <= '0;
        tline_q <= LINE_W'(1);
        tcol_q  <= COL_W'(1);
        len_q   <= '0;
        over_q  <= 1'b0;
        pfx_q   <= '0;
      end else begin
        mode_q  <= mode_d;
        pos_q   <= pos_d;
        line_q  <= line_d;
        col_q   <= col_d;
        tofs_q  <= tofs_d;
        tline_q <= tline_d;
        tcol_q  <= tcol_d;
        len_q   <= len_d;
        over_q  <= over_d;
        pfx_q   <= pfx_d;
      end
    end
  end

  `STT_ASSERT_NEXT(a_end_restarts, accept && in_data_i.end_of_text, mode_q == MODE_IDLE && pos_q == '0 && line_q == LINE_W'(1) && col_q == COL_W'(1), "text end did not restart scanner")
  `STT_ASSERT_IMPL(a_push_nonempty, push_o, bundle_o.cnt != '0, "empty bundle pushed")
  `STT_ASSERT_IMPL(a_end_is_last, push_o && in_data_i.end_of_text, bundle_o.tok[bundle_o.cnt - SLOT_W'(1)].token_kind == KIND_END, "End token not last in bundle")
  `STT_ASSERT_IMPL(a_quiet_item, in_valid_i && !in_data_i.byte_present && !in_data_i.end_of_text, !push_o, "empty transaction produced tokens")

endmodule

### sv/stt_queue.sv
`timescale 1ns / 1ps
module stt_queue import stt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output bundle_t data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t          mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= bump(wr_ptr_q);
      if (pop_i) rd_ptr_q <= bump(rd_ptr_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

### sv/stt_back.sv
`timescale 1ns / 1ps
`include "source_text_tokenizer_macros.svh"
module stt_back import stt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  bundle_t   q_data_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  bundle_t           bnd_q;
  logic              vld_q;
  logic [SLOT_W-1:0] idx_q;
  logic              run_last, take;

  assign run_last = idx_q == bnd_q.cnt - SLOT_W'(1);
  assign take     = vld_q && out_ready_i;
  // refill when empty or as the last token of the current bundle leaves
  assign pop_o    = q_valid_i && (!vld_q || (take && run_last));

  always_comb begin
    out_data_o             = bnd_q.tok[idx_q];
    out_data_o.last_of_run = run_last;
  end
  assign out_valid_o = vld_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) bnd_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (take) begin
      if (run_last) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + SLOT_W'(1);
      end
    end
  end

  `STT_ASSERT_IMPL(a_idx_in_range, vld_q, idx_q < bnd_q.cnt, "token index beyond bundle")
  `STT_ASSERT_IMPL(a_bundle_nonempty, vld_q, bnd_q.cnt != '0, "empty bundle loaded")
  `STT_ASSERT_NEXT(a_run_continues, take && !run_last, vld_q && idx_q == $past(idx_q) + SLOT_W'(1), "bundle cut short")

endmodule

### sv/source_text_tokenizer.sv
`timescale 1ns / 1ps
// Channel  | Handshake              | Payload
// input    | in_valid_i, in_ready_o | in_data_i  (in_item_t, one source byte)
// output   | out_valid_o, out_ready_i | out_data_o (out_item_t, one token)
//
// Takes one byte per cycle; a byte that yields two or three tokens holds the
// output for all of them, one token per cycle from the output register
// while out_ready_i is high. A two-bundle queue between scanner and output
// lets the scanner keep going while tokens wait; input stalls only when that
// queue is full. A byte's bundle passes through the queue and then the
// output register before out_valid_o rises.
// Reset is asynchronous, active low; the scanner starts at offset 0, line 1.
module source_text_tokenizer import stt_pkg::*; #(
  parameter int OFFSET_BITS = STT_OFFSET_BITS,
  parameter int LINE_BITS   = STT_LINE_BITS,
  parameter int COLUMN_BITS = STT_COLUMN_BITS,
  parameter int LENGTH_BITS = STT_LENGTH_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic    push, full, pop, q_valid;
  bundle_t push_bundle, q_bundle;

  assign in_ready_o = !full;

  stt_front #(
    .OFS_W  (OFFSET_BITS),
    .LINE_W (LINE_BITS),
    .COL_W  (COLUMN_BITS),
    .LEN_W  (LENGTH_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .bundle_o   (push_bundle)
  );

  stt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_bundle),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_bundle)
  );

  stt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_bundle),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
